// ----- rtl/core/lhp_pkg.sv -----
package lhp_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_BINS_DEF       = 65536;
    localparam int OVERFLOW_DEPTH_DEF = 64;
    localparam int COUNT_WIDTH_DEF    = 32;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int PCT_W    = 14;
    localparam int SUM_W    = 48;
    localparam int RESULT_W = 32;
    localparam int WARM_W   = 16;
    localparam int FUNC_W   = 2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Full scale of a percentile, in hundredths of a percent
    localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;

    // Function codes on the input channel
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_QUERY,
        OP_STAT
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_WARMUP = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_MISS   = 2'd3
    } status_t;

    // One classified item as it waits in the queue
    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
        logic                in_bins;
        logic [PCT_W-1:0]    pct;
    } item_t;

    // Configuration write toward the back end
    typedef struct packed {
        logic              load;
        logic [WARM_W-1:0] warmup;
    } cfg_t;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_BIN_WR,
        BS_OV_RD,
        BS_OV_CMP,
        BS_OV_PUT,
        BS_MUL,
        BS_DIV,
        BS_SCAN,
        BS_OV_PICK
    } back_state_t;

endpackage

// ----- rtl/core/lhp_front.sv -----
module lhp_front #(
    parameter int NUM_BINS = lhp_pkg::NUM_BINS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // sample[31:0], percentile[45:32], zero pad
    input  logic [lhp_pkg::FUNC_W-1:0] s_tuser,   // func[1:0]
    output logic                       q_valid,
    output lhp_pkg::item_t             q_item,
    input  logic                       q_pop
);
    import lhp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    item_t              item_in;
    logic               push;
    logic [SAMPLE_W-1:0] smp;
    logic [PCT_W-1:0]   pct_raw;

    assign smp     = s_tdata[SAMPLE_W-1:0];
    assign pct_raw = s_tdata[SAMPLE_W+PCT_W-1:SAMPLE_W];

    // Classify the incoming transfer
    always_comb
    begin
        case (s_tuser)
            FUNC_ADD:   item_in.op = OP_ADD;
            FUNC_QUERY: item_in.op = OP_QUERY;
            default:    item_in.op = OP_STAT;
        endcase
        item_in.sample  = smp;
        item_in.in_bins = ({1'b0, smp} < 33'(NUM_BINS));
        item_in.pct     = (pct_raw > PCT_FULL) ? PCT_FULL : pct_raw;
    end

    assign s_tready = (cnt_reg < CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- rtl/core/lhp_back.sv -----
module lhp_back #(
    parameter int NUM_BINS       = lhp_pkg::NUM_BINS_DEF,
    parameter int OVERFLOW_DEPTH = lhp_pkg::OVERFLOW_DEPTH_DEF,
    parameter int COUNT_WIDTH    = lhp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lhp_pkg::cfg_t                cfg,
    input  logic                         q_valid,
    input  lhp_pkg::item_t               q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lhp_pkg::RESULT_W-1:0] out_value,
    output logic [31:0]                  out_count,
    output logic [lhp_pkg::SUM_W-1:0]    out_sum,
    output lhp_pkg::status_t             out_status
);
    import lhp_pkg::*;

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int IDX_W  = $clog2(NUM_BINS + 1);
    localparam int OVI_W  = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(OVERFLOW_DEPTH + 1);
    localparam int PROD_W = COUNT_WIDTH + PCT_W;
    localparam int CUM_W  = COUNT_WIDTH + BIN_W + 1;
    localparam int CMP_W  = (CUM_W > PROD_W) ? CUM_W : PROD_W;

    // Target = floor(product / 10000) = floor((product >> 4) / 625), taken as a
    // multiply by a rounded-up reciprocal of 625, 16 reciprocal bits per cycle
    localparam int Y_W    = PROD_W - 4;
    localparam int RCP_SH = Y_W + 10;
    localparam int RCP_W  = Y_W + 1;
    localparam int NCH    = (RCP_W + 15) / 16;
    localparam int RCPP_W = 16 * NCH;
    localparam int ACC_W  = Y_W + RCPP_W;
    localparam int DCNT_W = $clog2(NCH + 1);
    localparam logic [127:0]      RCP_FULL = ((128'd1 << RCP_SH) + 128'd624) / 128'd625;
    localparam logic [RCPP_W-1:0] RCP_PAD  = RCPP_W'(RCP_FULL);

    // Storage
    logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
    logic [SAMPLE_W-1:0]    ov_mem  [OVERFLOW_DEPTH];

    back_state_t            state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [BIN_W-1:0]       clr_idx_reg, clr_idx_next;
    logic [WARM_W-1:0]      warm_reg, warm_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [OVI_W-1:0]       ovj_reg, ovj_next;
    logic [PROD_W-1:0]      dv_reg, dv_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [RCPP_W-1:0]      rcp_reg, rcp_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [BIN_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [CUM_W-1:0]       cum_reg, cum_next;
    logic                   out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]    out_value_reg, out_value_next;
    status_t                out_status_reg, out_status_next;

    logic                   bin_we;
    logic [BIN_W-1:0]       bin_waddr, bin_raddr;
    logic [COUNT_WIDTH-1:0] bin_wdata, bin_rdata_reg;
    logic                   ov_we;
    logic [OVI_W-1:0]       ov_waddr, ov_raddr;
    logic [SAMPLE_W-1:0]    ov_wdata, ov_rdata_reg;

    logic                   rec_en;
    logic [SAMPLE_W-1:0]    rec_val;
    logic [SUM_W:0]         sum_wide;
    logic [Y_W+15:0]        mul_prod;
    logic [ACC_W-1:0]       acc_new;
    logic [CUM_W-1:0]       cum_new;
    logic [CMP_W-1:0]       remain;
    logic [63:0]            count_ext;

    // Main sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        clr_idx_next    = clr_idx_reg;
        warm_next       = warm_reg;
        fill_next       = fill_reg;
        ovj_next        = ovj_reg;
        dv_next         = dv_reg;
        acc_next        = acc_reg;
        rcp_next        = rcp_reg;
        dcnt_next       = dcnt_reg;
        scan_idx_next   = scan_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        cum_next        = cum_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        bin_we          = 1'b0;
        bin_waddr       = item_reg.sample[BIN_W-1:0];
        bin_wdata       = (&bin_rdata_reg) ? bin_rdata_reg : bin_rdata_reg + 1'b1;
        bin_raddr       = scan_idx_reg[BIN_W-1:0];
        ov_we           = 1'b0;
        ov_waddr        = ovj_reg + 1'b1;
        ov_wdata        = item_reg.sample;
        ov_raddr        = ovj_reg;
        rec_en          = 1'b0;
        rec_val         = item_reg.sample;
        mul_prod        = {16'b0, dv_reg[PROD_W-1:4]}
                          * {{Y_W{1'b0}}, rcp_reg[RCPP_W-1 -: 16]};
        acc_new         = {acc_reg[ACC_W-17:0], 16'b0} + ACC_W'(mul_prod);
        cum_new         = cum_reg + CUM_W'(bin_rdata_reg);
        remain          = CMP_W'(dv_reg) - CMP_W'(cum_reg);

        // Drop the result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BS_CLEAR:
            begin
                bin_we    = 1'b1;
                bin_waddr = clr_idx_reg;
                bin_wdata = '0;
                if (clr_idx_reg == BIN_W'(NUM_BINS - 1))
                begin
                    state_next = BS_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            BS_IDLE:
            begin
                rec_val   = q_item.sample;
                bin_raddr = q_item.sample[BIN_W-1:0];
                if (q_valid && !out_valid_reg)
                begin
                    q_pop           = 1'b1;
                    item_next       = q_item;
                    out_value_next  = '0;
                    out_status_next = STAT_OK;
                    case (q_item.op)
                        OP_ADD:
                        begin
                            if (warm_reg != '0)
                            begin
                                warm_next       = warm_reg - 1'b1;
                                out_status_next = STAT_WARMUP;
                                out_valid_next  = 1'b1;
                            end
                            else if (q_item.in_bins)
                            begin
                                state_next = BS_BIN_WR;
                            end
                            else if (fill_reg >= FILL_W'(OVERFLOW_DEPTH))
                            begin
                                out_status_next = STAT_FULL;
                                out_valid_next  = 1'b1;
                            end
                            else if (fill_reg == '0)
                            begin
                                ov_we          = 1'b1;
                                ov_waddr       = '0;
                                ov_wdata       = q_item.sample;
                                fill_next      = fill_reg + 1'b1;
                                rec_en         = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ovj_next   = OVI_W'(fill_reg - 1'b1);
                                state_next = BS_OV_RD;
                            end
                        end
                        OP_QUERY:
                        begin
                            state_next = BS_MUL;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            BS_BIN_WR:
            begin
                bin_we          = 1'b1;
                rec_en          = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = BS_IDLE;
            end

            BS_OV_RD:
            begin
                state_next = BS_OV_CMP;
            end

            BS_OV_CMP:
            begin
                // Shift larger entries up one place, stop at the first smaller or equal
                ov_we = 1'b1;
                if (ov_rdata_reg > item_reg.sample)
                begin
                    ov_wdata = ov_rdata_reg;
                    if (ovj_reg == '0)
                    begin
                        state_next = BS_OV_PUT;
                    end
                    else
                    begin
                        ovj_next   = ovj_reg - 1'b1;
                        state_next = BS_OV_RD;
                    end
                end
                else
                begin
                    fill_next      = fill_reg + 1'b1;
                    rec_en         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BS_IDLE;
                end
            end

            BS_OV_PUT:
            begin
                ov_we          = 1'b1;
                ov_waddr       = '0;
                fill_next      = fill_reg + 1'b1;
                rec_en         = 1'b1;
                out_valid_next = 1'b1;
                state_next     = BS_IDLE;
            end

            BS_MUL:
            begin
                dv_next    = PROD_W'(count_reg) * PROD_W'(item_reg.pct);
                acc_next   = '0;
                rcp_next   = RCP_PAD;
                dcnt_next  = '0;
                state_next = BS_DIV;
            end

            BS_DIV:
            begin
                // Accumulate one 16-bit slice of the reciprocal per cycle, top slice first
                acc_next  = acc_new;
                rcp_next  = rcp_reg << 16;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(NCH - 1))
                begin
                    dv_next       = PROD_W'(acc_new >> RCP_SH);
                    scan_idx_next = '0;
                    chk_vld_next  = 1'b0;
                    cum_next      = '0;
                    state_next    = BS_SCAN;
                end
            end

            BS_SCAN:
            begin
                // Issue one bin read per cycle, check the one read last cycle
                if (scan_idx_reg < IDX_W'(NUM_BINS))
                begin
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_idx_reg[BIN_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    cum_next = cum_new;
                    if (CMP_W'(cum_new) >= CMP_W'(dv_reg))
                    begin
                        out_value_next = RESULT_W'(chk_idx_reg);
                        out_valid_next = 1'b1;
                        state_next     = BS_IDLE;
                    end
                end
                else if (scan_idx_reg == IDX_W'(NUM_BINS))
                begin
                    if (remain <= CMP_W'(fill_reg))
                    begin
                        ov_raddr   = OVI_W'(remain - 1'b1);
                        state_next = BS_OV_PICK;
                    end
                    else
                    begin
                        out_status_next = STAT_MISS;
                        out_valid_next  = 1'b1;
                        state_next      = BS_IDLE;
                    end
                end
            end

            BS_OV_PICK:
            begin
                out_value_next = ov_rdata_reg;
                out_valid_next = 1'b1;
                state_next     = BS_IDLE;
            end

            default:
            begin
                state_next = BS_IDLE;
            end
        endcase

        // Configuration reloads the warm-up counter
        if (cfg.load)
        begin
            warm_next = cfg.warmup;
        end
    end

    // Update running statistics
    always_comb
    begin
        count_next = count_reg;
        sum_wide   = {1'b0, sum_reg} + (SUM_W + 1)'(rec_val);
        sum_next   = sum_reg;
        if (rec_en)
        begin
            if (!(&count_reg))
            begin
                count_next = count_reg + 1'b1;
            end
            sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_CLEAR;
            clr_idx_reg   <= '0;
            warm_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            fill_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            warm_reg      <= warm_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        ovj_reg        <= ovj_next;
        dv_reg         <= dv_next;
        acc_reg        <= acc_next;
        rcp_reg        <= rcp_next;
        dcnt_reg       <= dcnt_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        cum_reg        <= cum_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // Bin memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        bin_rdata_reg <= bin_mem[bin_raddr];
    end

    // Sorted overflow memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ov_we)
        begin
            ov_mem[ov_waddr] <= ov_wdata;
        end
        ov_rdata_reg <= ov_mem[ov_raddr];
    end

    assign count_ext  = 64'(count_reg);
    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_count  = (|count_ext[63:32]) ? 32'hFFFF_FFFF : count_ext[31:0];
    assign out_sum    = sum_reg;
    assign out_status = out_status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(OVERFLOW_DEPTH))
        else $error("overflow fill beyond depth");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BS_IDLE) && !out_valid_reg)
        else $error("item taken while busy");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("recorded count went down");

    a_bin_write: assert property (@(posedge clk) disable iff (!rst_n)
        bin_we |-> (state_reg == BS_CLEAR) || (state_reg == BS_BIN_WR))
        else $error("bin written outside clear or add");

endmodule

// ----- rtl/core/latency_histogram_percentile_unit.sv -----
// Channel   Direction  Ports                              Content
// s_        in         s_tvalid/s_tready/s_tdata/s_tuser  add, percentile query, statistics read
// m_        out        m_tvalid/m_tready/m_tdata          value, count, sum, status
// apb       in/out     psel/penable/pwrite/paddr/...      warmup_samples at byte address 0
//
// Add into a bin passes through a bin write state; warm-up, full store and statistics
// answer straight from idle. Add into the overflow store reads and compares each larger
// entry in turn to shift it up. Query: the product, then the reciprocal multiply by 1/10000
// one 16-bit slice at a time, then the bin scan at one read per cycle.
// After reset the bin memory is cleared one bin at a time; input transfers
// queue (two deep) meanwhile. A result waiting on m_tready holds the back end.
module latency_histogram_percentile_unit #(
    parameter int NUM_BINS       = lhp_pkg::NUM_BINS_DEF,
    parameter int OVERFLOW_DEPTH = lhp_pkg::OVERFLOW_DEPTH_DEF,
    parameter int COUNT_WIDTH    = lhp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // sample[31:0], percentile[45:32], zero pad
    input  logic [lhp_pkg::FUNC_W-1:0] s_tuser,   // func[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [119:0]               m_tdata,   // value[31:0], count[63:32],
                                                  // sum[111:64], status[113:112], zero pad
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lhp_pkg::*;

    localparam logic [1:0] ADDR_WARMUP = 2'd0;

    logic [WARM_W-1:0]   warmup_reg;
    cfg_t                cfg;
    logic                q_valid;
    item_t               q_item;
    logic                q_pop;
    logic [RESULT_W-1:0] out_value;
    logic [31:0]         out_count;
    logic [SUM_W-1:0]    out_sum;
    status_t             out_status;

    // Register port
    assign pready     = 1'b1;
    assign cfg.load   = psel && penable && pwrite;
    assign cfg.warmup = pwdata[WARM_W-1:0];
    assign prdata     = (paddr == ADDR_WARMUP) ? {16'd0, warmup_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg <= '0;
        end
        else if (cfg.load)
        begin
            warmup_reg <= cfg.warmup;
        end
    end

    lhp_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lhp_back #(
        .NUM_BINS       (NUM_BINS),
        .OVERFLOW_DEPTH (OVERFLOW_DEPTH),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_count  (out_count),
        .out_sum    (out_sum),
        .out_status (out_status)
    );

    // Pack the result transfer
    assign m_tdata = {6'd0, out_status, out_sum, out_count, out_value};

endmodule

// ----- tb/sv/latency_histogram_percentile_checker.sv -----
module latency_histogram_percentile_checker
    import lhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,   // sample[31:0], percentile[45:32], zero pad
    input  logic [1:0]   s_tuser,   // func[1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,   // value[31:0], count[63:32], sum[111:64], status[113:112]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BINS      = NUM_BINS_DEF;
    localparam int          OVF_DEPTH = OVERFLOW_DEPTH_DEF;
    localparam logic [1:0]  ADDR_WARMUP = 2'd0;

    typedef struct {
        logic [31:0] value;
        logic [31:0] count;
        logic [47:0] sum;
        status_t     status;
    } hist_result_t;

    // Shadow copy of the histogram
    logic [31:0]  bin_cnt [int];
    logic [31:0]  ovf_sorted [$];
    logic [31:0]  rec_count;
    logic [47:0]  rec_sum;
    logic [15:0]  warm_left;
    hist_result_t expected_results [$];
    int           err_cnt;

    assign errors  = err_cnt;

    task automatic record_sample(input logic [31:0] smp);
        logic [48:0] acc;
        begin
            if (rec_count != 32'hFFFF_FFFF)
                rec_count++;
            acc = {1'b0, rec_sum} + {17'b0, smp};
            rec_sum = acc[48] ? 48'hFFFF_FFFF_FFFF : acc[47:0];
        end
    endtask

    // Work out the result of one accepted input transfer
    task automatic predict_item(input logic [1:0] fn, input logic [31:0] smp,
                                input logic [13:0] pct_in);
        hist_result_t r;
        logic [63:0]  target;
        logic [63:0]  cum;
        logic [13:0]  pct;
        int           k;
        int           pos;
        bit           found;
        begin
            r.value  = '0;
            r.status = STAT_OK;
            if (fn == FUNC_ADD) begin
                if (warm_left != 0) begin
                    warm_left--;
                    r.status = STAT_WARMUP;
                end else if (smp < BINS) begin
                    k = int'(smp);
                    if (!bin_cnt.exists(k))
                        bin_cnt[k] = 32'd1;
                    else if (bin_cnt[k] != 32'hFFFF_FFFF)
                        bin_cnt[k] = bin_cnt[k] + 1;
                    record_sample(smp);
                end else if (ovf_sorted.size() >= OVF_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // keep the store sorted, equal values stay in arrival order
                    pos = 0;
                    while (pos < ovf_sorted.size() && ovf_sorted[pos] <= smp)
                        pos++;
                    ovf_sorted.insert(pos, smp);
                    record_sample(smp);
                end
            end else if (fn == FUNC_QUERY) begin
                pct    = (pct_in > PCT_FULL) ? PCT_FULL : pct_in;
                target = ({32'b0, rec_count} * {50'b0, pct}) / 64'd10000;
                cum    = '0;
                found  = 0;
                if (target == 0) begin
                    found = 1;
                end else begin
                    // walk the nonzero bins in ascending order
                    if (bin_cnt.first(k)) begin
                        do begin
                            cum += {32'b0, bin_cnt[k]};
                            if (cum >= target) begin
                                r.value = 32'(k);
                                found   = 1;
                            end
                        end while (!found && bin_cnt.next(k));
                    end
                    for (int i = 0; i < ovf_sorted.size() && !found; i++) begin
                        cum++;
                        if (cum >= target) begin
                            r.value = ovf_sorted[i];
                            found   = 1;
                        end
                    end
                end
                if (!found)
                    r.status = STAT_MISS;
            end
            r.count = rec_count;
            r.sum   = rec_sum;
            expected_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hist_result_t exp_r;
        if (!rst_n) begin
            bin_cnt.delete();
            ovf_sorted.delete();
            expected_results.delete();
            rec_count = '0;
            rec_sum   = '0;
            warm_left = '0;
            err_cnt   = 0;
            pending   = 0;
        end else begin
            // reload the warm-up counter on a register write
            if (psel && penable && pwrite && pready && paddr == ADDR_WARMUP)
                warm_left = pwdata[15:0];
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata[31:0], s_tdata[45:32]);
            // compare each result transfer with the oldest expectation
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
                    err_cnt++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[31:0] !== exp_r.value) begin
                        $display("%0t: value expected %0d actual %0d",
                                 $time, exp_r.value, m_tdata[31:0]);
                        err_cnt++;
                    end
                    if (m_tdata[63:32] !== exp_r.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, exp_r.count, m_tdata[63:32]);
                        err_cnt++;
                    end
                    if (m_tdata[111:64] !== exp_r.sum) begin
                        $display("%0t: sum expected %0d actual %0d",
                                 $time, exp_r.sum, m_tdata[111:64]);
                        err_cnt++;
                    end
                    if (m_tdata[113:112] !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_tdata[113:112]);
                        err_cnt++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_latency_histogram_percentile_unit.sv -----
module tb_latency_histogram_percentile_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import lhp_pkg::*;

    localparam logic [1:0] FUNC_STAT   = 2'd2;
    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam logic [1:0] ADDR_WARMUP = 2'd0;
    localparam int         IDLE_LIMIT  = 300000;
    localparam int         RANDOM_ITEMS = 1700;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           errors;
    int           pending;
    int           burst_left;
    int           idle_cycles;
    int           hold_cnt;
    int           stall_phase;
    bit           hold_go;
    bit           hold_done;

    latency_histogram_percentile_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    latency_histogram_percentile_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one transfer and hold it until accepted, then maybe idle
    task automatic send_item(input logic [1:0] fn, input logic [31:0] smp,
                             input logic [13:0] pct);
        int gap;
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= fn;
            s_tdata  <= {2'b00, pct, smp};
            do @(posedge clk); while (!s_tready);
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                         : $urandom_range(0, 30);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Two-phase register write
    task automatic write_warmup(input logic [15:0] val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_WARMUP;
            pwdata  <= {16'b0, val};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Lower valid and wait for every outstanding result
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
            repeat (20) @(posedge clk);
        end
    endtask

    // Receiver: stall pattern, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready    <= 1'b0;
            hold_cnt    = 0;
            stall_phase = 0;
            hold_done   = 0;
        end else begin
            if (hold_go && !hold_done) begin
                hold_cnt  = 600;
                hold_done = 1;
            end
            stall_phase = (stall_phase + 1) % 512;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (stall_phase < 128) begin
                m_tready <= 1'b1;
            end else if (stall_phase < 320) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_tready <= (stall_phase[2:0] != 3'd5) && ($urandom_range(0, 1) == 1);
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_latency_histogram_percentile_unit: errors");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]  fn;
        logic [31:0] smp;
        logic [13:0] pct;
        int          pick;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        burst_left  = 10;
        idle_cycles = 0;
        hold_go     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: warm-up discard, edges, every function code
        write_warmup(16'd2);
        send_item(FUNC_ADD, 32'd5, 14'd0);
        send_item(FUNC_ADD, 32'd7, 14'd0);
        send_item(FUNC_QUERY, 32'd0, 14'd5000);
        send_item(FUNC_ADD, 32'd0, 14'h3FFF);
        send_item(FUNC_ADD, 32'd65535, 14'd0);
        send_item(FUNC_ADD, 32'd65536, 14'd0);
        send_item(FUNC_ADD, 32'hFFFF_FFFF, 14'd0);
        send_item(FUNC_ADD, 32'd100, 14'd0);
        send_item(FUNC_ADD, 32'd100, 14'd0);
        send_item(FUNC_ADD, 32'hAAAA_AAAA, 14'h2AAA);
        send_item(FUNC_ADD, 32'h5555_5555, 14'h1555);
        send_item(FUNC_QUERY, 32'hFFFF_FFFF, 14'd0);
        send_item(FUNC_QUERY, 32'd0, 14'd10000);
        send_item(FUNC_QUERY, 32'd0, 14'h3FFF);
        send_item(FUNC_QUERY, 32'd0, 14'd5000);
        send_item(FUNC_STAT, 32'hFFFF_FFFF, 14'h3FFF);
        send_item(FUNC_SPARE, 32'h1234_5678, 14'd77);
        drain();

        // largest warm-up, then reload to zero before it runs out
        write_warmup(16'hFFFF);
        for (int i = 0; i < 20; i++)
            send_item(FUNC_ADD, $urandom, 14'd0);
        drain();
        write_warmup(16'd0);

        // random traffic, queries kept rare since each may scan all bins
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 400)
                hold_go = 1;
            if (i == 850) begin
                drain();
                write_warmup(16'($urandom_range(1, 30)));
            end
            pick = $urandom_range(0, 999);
            smp  = $urandom;
            pct  = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 16383))
                                               : 14'($urandom_range(0, 10000));
            if (pick < 4) begin
                fn = FUNC_QUERY;
            end else if (pick < 60) begin
                fn = FUNC_STAT;
            end else if (pick < 80) begin
                fn = FUNC_SPARE;
            end else begin
                fn = FUNC_ADD;
                if (pick < 600)
                    smp = $urandom_range(0, 255);
                else if (pick < 880)
                    smp = $urandom_range(0, 65535);
                else if (pick < 900)
                    smp = 32'd65536;
            end
            send_item(fn, smp, pct);
        end
        drain();

        if (errors == 0)
            $display("tb_latency_histogram_percentile_unit: clean");
        else
            $display("tb_latency_histogram_percentile_unit: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lhp_pkg.sv
rtl/core/lhp_front.sv
rtl/core/lhp_back.sv
rtl/core/latency_histogram_percentile_unit.sv
tb/sv/latency_histogram_percentile_checker.sv
tb/sv/tb_latency_histogram_percentile_unit.sv
